### hw/rtl/cle_pkg.sv
package cle_pkg;

    // Largest line the editor ever builds; the configured limit is clamped to it when used.
    localparam int unsigned MAX_LINE = 256;

    localparam int unsigned CHAR_W    = 8;
    localparam int unsigned INDEX_W   = 8;
    localparam int unsigned LENGTH_W  = 9;
    localparam int unsigned KIND_W    = 2;
    localparam int unsigned COUNT_W   = 9;

    // One byte causes at most this many results.
    localparam int unsigned RESULT_SLOTS = 4;
    localparam int unsigned NUM_W        = $clog2(RESULT_SLOTS + 1);

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_ECHO  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_STORE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DONE  = 2'd2;

    // Control characters.
    localparam logic [CHAR_W-1:0] CH_EOT    = 8'd4;
    localparam logic [CHAR_W-1:0] CH_BS_KEY = 8'd127;
    localparam logic [CHAR_W-1:0] CH_LF     = 8'd10;
    localparam logic [CHAR_W-1:0] CH_CR     = 8'd13;
    localparam logic [CHAR_W-1:0] CH_BACK   = 8'd8;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'd32;

    localparam logic [LENGTH_W-1:0] LIMIT_RESET = LENGTH_W'(MAX_LINE);

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [CHAR_W-1:0]   char_value;
        logic [INDEX_W-1:0]  index;
        logic [LENGTH_W-1:0] length;
    } result_t;

    typedef result_t [RESULT_SLOTS-1:0] result_vec_t;

    // Outcome of one byte: how many results and the line state it leaves.
    typedef struct packed {
        logic [NUM_W-1:0]   num;
        logic [COUNT_W-1:0] position;
        logic [COUNT_W-1:0] consumed;
    } step_t;

    function automatic result_t make_result(
        input logic [KIND_W-1:0]   kind,
        input logic [CHAR_W-1:0]   ch,
        input logic [INDEX_W-1:0]  idx,
        input logic [LENGTH_W-1:0] len
    );
        result_t r;
        r.kind       = kind;
        r.char_value = ch;
        r.index      = idx;
        r.length     = len;
        return r;
    endfunction

endpackage

### hw/rtl/cle_decode.sv
module cle_decode (
    input  logic [cle_pkg::CHAR_W-1:0]   in_char,
    input  logic [cle_pkg::LENGTH_W-1:0] max_length,
    input  logic [cle_pkg::COUNT_W-1:0]  position,
    input  logic [cle_pkg::COUNT_W-1:0]  consumed,
    output cle_pkg::result_vec_t         results,
    output cle_pkg::step_t               step
);
    import cle_pkg::*;

    logic [COUNT_W-1:0] limit;
    logic [COUNT_W-1:0] consumed_inc;
    logic [COUNT_W-1:0] position_inc;
    logic [COUNT_W-1:0] position_dec;
    logic               done;

    always_comb
    begin
        if (max_length == '0)
        begin
            limit = COUNT_W'(1);
        end
        else if (max_length > LIMIT_RESET)
        begin
            limit = LIMIT_RESET;
        end
        else
        begin
            limit = max_length;
        end
    end

    assign consumed_inc = consumed + COUNT_W'(1);
    assign position_inc = position + COUNT_W'(1);
    assign position_dec = position - COUNT_W'(1);
    assign done         = (consumed_inc >= limit);

    always_comb
    begin
        results       = '0;
        step.num      = '0;
        step.position = position;
        step.consumed = consumed;

        if (in_char == CH_EOT)
        begin
            results[0]    = make_result(KIND_DONE, '0, '0, position);
            step.num      = NUM_W'(1);
            step.position = '0;
            step.consumed = '0;
        end
        else if ((in_char == CH_LF) || (in_char == CH_CR))
        begin
            results[0]    = make_result(KIND_STORE, in_char, position[INDEX_W-1:0], '0);
            results[1]    = make_result(KIND_ECHO, CH_LF, '0, '0);
            results[2]    = make_result(KIND_DONE, '0, '0, position_inc);
            step.num      = NUM_W'(3);
            step.position = '0;
            step.consumed = '0;
        end
        else if (in_char == CH_BS_KEY)
        begin
            if (position == '0)
            begin
                // Nothing to erase; only the byte count moves, and the line ends if that reaches the limit.
                if (done)
                begin
                    results[0] = make_result(KIND_DONE, '0, '0, position);
                    step.num   = NUM_W'(1);
                end
            end
            else if (done)
            begin
                // The cleared entry lies past the finished line, so its store is dropped.
                results[0] = make_result(KIND_ECHO, CH_BACK, '0, '0);
                results[1] = make_result(KIND_ECHO, CH_SPACE, '0, '0);
                results[2] = make_result(KIND_ECHO, CH_BACK, '0, '0);
                results[3] = make_result(KIND_DONE, '0, '0, position_dec);
                step.num   = NUM_W'(4);
            end
            else
            begin
                results[0] = make_result(KIND_STORE, '0, position_dec[INDEX_W-1:0], '0);
                results[1] = make_result(KIND_ECHO, CH_BACK, '0, '0);
                results[2] = make_result(KIND_ECHO, CH_SPACE, '0, '0);
                results[3] = make_result(KIND_ECHO, CH_BACK, '0, '0);
                step.num   = NUM_W'(4);
            end

            if (done)
            begin
                step.position = '0;
                step.consumed = '0;
            end
            else
            begin
                step.position = (position == '0) ? position : position_dec;
                step.consumed = consumed_inc;
            end
        end
        else
        begin
            results[0] = make_result(KIND_STORE, in_char, position[INDEX_W-1:0], '0);
            results[1] = make_result(KIND_ECHO, in_char, '0, '0);
            if (done)
            begin
                results[2]    = make_result(KIND_DONE, '0, '0, position_inc);
                step.num      = NUM_W'(3);
                step.position = '0;
                step.consumed = '0;
            end
            else
            begin
                step.num      = NUM_W'(2);
                step.position = position_inc;
                step.consumed = consumed_inc;
            end
        end
    end

endmodule

### hw/rtl/cle_serializer.sv
module cle_serializer (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load_en,
    input  logic [cle_pkg::NUM_W-1:0]   load_num,
    input  cle_pkg::result_vec_t        load_results,
    output logic                        load_ready,
    output logic                        out_valid,
    input  logic                        out_ready,
    output cle_pkg::result_t            head,
    output logic                        head_last
);
    import cle_pkg::*;

    result_vec_t        slot_reg;
    result_vec_t        slot_next;
    logic [NUM_W-1:0]   count_reg;
    logic [NUM_W-1:0]   count_next;
    logic               transfer;
    logic               do_load;

    assign out_valid  = (count_reg != '0);
    assign transfer   = out_valid && out_ready;
    assign head_last  = (count_reg == NUM_W'(1));
    assign head       = slot_reg[0];
    // A new group may enter once the current one is gone or its last entry leaves now.
    assign load_ready = (count_reg == '0) || (head_last && out_ready);
    assign do_load    = load_en && load_ready;

    always_comb
    begin
        slot_next  = slot_reg;
        count_next = count_reg;
        if (do_load)
        begin
            slot_next  = load_results;
            count_next = load_num;
        end
        else if (transfer)
        begin
            for (int i = 0; i < int'(RESULT_SLOTS) - 1; i++)
            begin
                slot_next[i] = slot_reg[i+1];
            end
            count_next = count_reg - NUM_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= NUM_W'(RESULT_SLOTS))
        else $error("result count out of range");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> $stable(count_reg))
        else $error("pending results changed during a stall");

    a_drain_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (transfer && head_last && !load_en) |=> (count_reg == '0))
        else $error("results remain after the last transfer");

endmodule

### hw/rtl/console_line_editor_unit.sv
// Console line editor. Console bytes enter one per transfer on the in_* channel and each
// one produces an ordered group of zero to four results on the out_* channel: stores into
// the external line buffer, echoes back to the console, and a line-finished result that
// carries the line length. Backspace erases the previous byte (echo BS, space, BS), LF or
// CR stores the byte, echoes LF and ends the line, EOT ends the line as it stands, and a
// line also ends once max_length bytes (backspaces included) have been taken; the limit
// is clamped to 1..256. The byte is decoded in the cycle after its transfer, and its first
// result is presented in the cycle after the serializer takes the group. Results leave one per
// cycle while out_ready is high; a byte with no results takes no place on the output. The
// single-result output port sets the sustained rate. A new byte is taken while earlier results
// are still waiting, held in the input register. The limit register is written through
// cfg_wr_en/cfg_wr_data and must only change while idle.
module console_line_editor_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [cle_pkg::LENGTH_W-1:0]  cfg_wr_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [cle_pkg::CHAR_W-1:0]    in_char,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [cle_pkg::KIND_W-1:0]    result_kind,
    output logic [cle_pkg::CHAR_W-1:0]    char_value,
    output logic [cle_pkg::INDEX_W-1:0]   buffer_index,
    output logic [cle_pkg::LENGTH_W-1:0]  line_length,
    output logic                          last_of_item
);
    import cle_pkg::*;

    // Configured byte limit; the decoder applies the clamp.
    logic [LENGTH_W-1:0] max_length_reg;

    // Input register: holds one accepted byte until the serializer takes its results.
    logic                hold_valid_reg;
    logic                hold_valid_next;
    logic [CHAR_W-1:0]   hold_char_reg;

    // Line state, updated when a byte's results are handed to the serializer.
    logic [COUNT_W-1:0]  position_reg;
    logic [COUNT_W-1:0]  consumed_reg;

    result_vec_t         results;
    step_t               step;
    result_t             head;
    logic                load_ready;
    logic                advance;
    logic                in_transfer;

    assign advance     = hold_valid_reg && load_ready;
    assign in_ready    = !hold_valid_reg || advance;
    assign in_transfer = in_valid && in_ready;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (in_transfer)
        begin
            hold_valid_next = 1'b1;
        end
        else if (advance)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_transfer)
        begin
            hold_char_reg <= in_char;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            max_length_reg <= LIMIT_RESET;
            position_reg   <= '0;
            consumed_reg   <= '0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            if (cfg_wr_en)
            begin
                max_length_reg <= cfg_wr_data;
            end
            if (advance)
            begin
                position_reg <= step.position;
                consumed_reg <= step.consumed;
            end
        end
    end

    cle_decode u_decode (
        .in_char    (hold_char_reg),
        .max_length (max_length_reg),
        .position   (position_reg),
        .consumed   (consumed_reg),
        .results    (results),
        .step       (step)
    );

    cle_serializer u_serializer (
        .clk          (clk),
        .rst_n        (rst_n),
        .load_en      (hold_valid_reg),
        .load_num     (step.num),
        .load_results (results),
        .load_ready   (load_ready),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .head         (head),
        .head_last    (last_of_item)
    );

    assign result_kind  = head.kind;
    assign char_value   = head.char_value;
    assign buffer_index = head.index;
    assign line_length  = head.length;

    // Every byte that grows the line is also counted, so the position never passes the count.
    a_position_le_count: assert property (@(posedge clk) disable iff (!rst_n)
        position_reg <= consumed_reg)
        else $error("line position ahead of byte count");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        consumed_reg < COUNT_W'(MAX_LINE))
        else $error("byte count reached the line limit without ending the line");

    a_hold_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (hold_valid_reg && !advance) |=> (hold_valid_reg && $stable(hold_char_reg)))
        else $error("held byte lost before its results were taken");

endmodule

### sim/tb_console_line_editor_unit.sv
`timescale 1ns / 1ps

module tb_console_line_editor_unit;

    import cle_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 8;
    // A byte with no result may still be inside the block when the last
    // expected result has left; this many cycles cover its decode and issue.
    localparam int DRAIN_CYCLES   = 12;
    // Longest stretch without any transfer before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 96;
    localparam int REPORT_LIMIT   = 10;

    // One result as the block should present it, with its end-of-byte flag.
    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [CHAR_W-1:0]   ch;
        logic [INDEX_W-1:0]  index;
        logic [LENGTH_W-1:0] length;
        logic                last;
    } editor_result_t;

    // Every input starts at a known value before the first clock edge.
    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                cfg_wr_en   = 1'b0;
    logic [LENGTH_W-1:0] cfg_wr_data = '0;
    logic                in_valid    = 1'b0;
    logic                in_ready;
    logic [CHAR_W-1:0]   in_char     = '0;
    logic                out_valid;
    logic                out_ready   = 1'b0;
    logic [KIND_W-1:0]   result_kind;
    logic [CHAR_W-1:0]   char_value;
    logic [INDEX_W-1:0]  buffer_index;
    logic [LENGTH_W-1:0] line_length;
    logic                last_of_item;

    // Bytes waiting to be offered, and results owed by the block, oldest first.
    logic [CHAR_W-1:0] console_bytes_queued[$];
    editor_result_t    line_results_due[$];

    // The testbench's own view of the editor: line state and the limit register.
    logic [COUNT_W-1:0]  cur_position  = '0;
    logic [COUNT_W-1:0]  cur_consumed  = '0;
    logic [LENGTH_W-1:0] limit_setting = LIMIT_RESET;

    int sender_idle_pct = 0;
    int recv_idle_pct   = 0;
    bit hold_request    = 1'b0;
    int hold_left       = 0;
    bit run_done        = 1'b0;
    int stall_cycles    = 0;

    int error_count     = 0;
    int bytes_accepted  = 0;
    int results_seen    = 0;
    int lines_finished  = 0;
    int limits_written  = 0;

    console_line_editor_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_char      (in_char),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_kind  (result_kind),
        .char_value   (char_value),
        .buffer_index (buffer_index),
        .line_length  (line_length),
        .last_of_item (last_of_item)
    );

    always #CLK_HALF clk = ~clk;

    function automatic editor_result_t result_of(
        input logic [KIND_W-1:0]   kind,
        input logic [CHAR_W-1:0]   ch,
        input logic [INDEX_W-1:0]  index,
        input logic [LENGTH_W-1:0] length
    );
        editor_result_t r;
        r.kind   = kind;
        r.ch     = ch;
        r.index  = index;
        r.length = length;
        r.last   = 1'b0;
        return r;
    endfunction

    // Applies one accepted console byte to the line state and appends the
    // results it must cause, in order, to the owed results.
    task automatic edit_line_with_byte(input logic [CHAR_W-1:0] c);
        editor_result_t     batch[$];
        logic [COUNT_W-1:0] lim;
        logic               line_full;
        // The register is used clamped to 1..MAX_LINE.
        if (limit_setting == '0)
            lim = COUNT_W'(1);
        else if (limit_setting > COUNT_W'(MAX_LINE))
            lim = COUNT_W'(MAX_LINE);
        else
            lim = limit_setting;

        if (c == CH_EOT)
        begin
            // End of transmission closes the line as it stands; nothing is stored.
            batch.push_back(result_of(KIND_DONE, '0, '0, cur_position));
            cur_position = '0;
            cur_consumed = '0;
        end
        else if (c == CH_LF || c == CH_CR)
        begin
            // The terminator itself is stored, and the console always sees LF.
            batch.push_back(result_of(KIND_STORE, c, INDEX_W'(cur_position), '0));
            batch.push_back(result_of(KIND_ECHO, CH_LF, '0, '0));
            batch.push_back(result_of(KIND_DONE, '0, '0, cur_position + 1'b1));
            cur_position = '0;
            cur_consumed = '0;
        end
        else
        begin
            // Ordinary bytes and backspaces both count against the limit.
            cur_consumed = cur_consumed + 1'b1;
            line_full    = (cur_consumed >= lim);
            if (c == CH_BS_KEY)
            begin
                if (cur_position != '0)
                begin
                    cur_position = cur_position - 1'b1;
                    // When the limit closes the line, the cleared entry lies past
                    // its end, so the store is dropped to keep four results.
                    if (!line_full)
                        batch.push_back(result_of(KIND_STORE, '0,
                                                  INDEX_W'(cur_position), '0));
                    batch.push_back(result_of(KIND_ECHO, CH_BACK, '0, '0));
                    batch.push_back(result_of(KIND_ECHO, CH_SPACE, '0, '0));
                    batch.push_back(result_of(KIND_ECHO, CH_BACK, '0, '0));
                end
            end
            else
            begin
                batch.push_back(result_of(KIND_STORE, c, INDEX_W'(cur_position), '0));
                batch.push_back(result_of(KIND_ECHO, c, '0, '0));
                cur_position = cur_position + 1'b1;
            end
            if (line_full)
            begin
                batch.push_back(result_of(KIND_DONE, '0, '0, cur_position));
                cur_position = '0;
                cur_consumed = '0;
            end
        end

        if (batch.size() != 0)
            batch[batch.size() - 1].last = 1'b1;
        foreach (batch[k])
            line_results_due.push_back(batch[k]);
    endtask

    // Input driver. The payload only changes when the channel is free after
    // this edge, so valid and the byte hold steady until the transfer happens.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                edit_line_with_byte(in_char);
                bytes_accepted++;
            end
            if (!in_valid || in_ready)
            begin
                if (console_bytes_queued.size() != 0 &&
                    $urandom_range(99) >= sender_idle_pct)
                begin
                    in_valid <= 1'b1;
                    in_char  <= console_bytes_queued.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Output receiver. A pending hold request turns into a long run of
    // deasserted ready, counted here, so the block backs up into its input.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left = 0;
        end
        else
        begin
            if (hold_request)
            begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Result monitor: every transfer on the output is matched against the
    // oldest owed result.
    always @(posedge clk)
    begin : result_check
        editor_result_t seen;
        editor_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            seen.kind   = result_kind;
            seen.ch     = char_value;
            seen.index  = buffer_index;
            seen.length = line_length;
            seen.last   = last_of_item;
            results_seen++;
            if (result_kind == KIND_DONE)
                lines_finished++;
            if (line_results_due.size() == 0)
            begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                    $display("%0t: result with nothing owed: ", $realtime,
                             "kind %0d char %0d index %0d length %0d last %0d",
                             seen.kind, seen.ch, seen.index, seen.length, seen.last);
            end
            else
            begin
                want = line_results_due.pop_front();
                if (seen !== want)
                begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                        $display("%0t: result %0d ", $realtime, results_seen,
                                 "expected kind %0d char %0d index %0d length %0d last %0d, ",
                                 want.kind, want.ch, want.index, want.length, want.last,
                                 "got kind %0d char %0d index %0d length %0d last %0d",
                                 seen.kind, seen.ch, seen.index, seen.length, seen.last);
                end
            end
        end
    end

    // Watchdog: a long stretch with no transfer on either channel means the
    // block has hung, whatever is still owed.
    always @(posedge clk)
    begin
        if (!rst_n || run_done || (in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles, %0d results still owed",
                     $realtime, stall_cycles, line_results_due.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic queue_byte(input logic [CHAR_W-1:0] c);
        console_bytes_queued.push_back(c);
    endtask

    // Any byte that the editor treats as plain text.
    function automatic logic [CHAR_W-1:0] plain_byte();
        logic [CHAR_W-1:0] c;
        do
            c = CHAR_W'($urandom_range(255));
        while (c == CH_EOT || c == CH_LF || c == CH_CR || c == CH_BS_KEY);
        return c;
    endfunction

    // Waits until every queued byte has been taken and every owed result has
    // come out, then gives a byte with no result time to leave the block.
    task automatic wait_until_idle();
        @(negedge clk);
        while (console_bytes_queued.size() != 0 || in_valid ||
               line_results_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Changes the limit between phases. The line in progress is kept, so a
    // lower limit can land below the bytes already taken.
    task automatic begin_phase(input logic [LENGTH_W-1:0] limit,
                               input int sender_pct, input int recv_pct);
        wait_until_idle();
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= limit;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        limit_setting = limit;
        limits_written++;
        @(negedge clk);
        sender_idle_pct = sender_pct;
        recv_idle_pct   = recv_pct;
    endtask

    // Mostly typed lines with some erasing and, most often, a terminator, mixed with raw
    // noise and with lines that erase past their start. Bare backspaces are
    // not counted, since at the start of a line they usually do nothing.
    task automatic queue_random_traffic(input int budget);
        int counted;
        int pick;
        int len;
        int k;
        counted = 0;
        while (counted < budget)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
            begin
                len = ($urandom_range(9) == 0) ? $urandom_range(12, 40) : $urandom_range(10);
                for (k = 0; k < len; k++)
                begin
                    if ($urandom_range(99) < 15)
                        queue_byte(CH_BS_KEY);
                    else
                    begin
                        queue_byte(CHAR_W'($urandom_range(32, 126)));
                        counted++;
                    end
                end
                case ($urandom_range(3))
                    0: queue_byte(CH_LF);
                    1: queue_byte(CH_CR);
                    2: queue_byte(CH_EOT);
                    default: queue_byte(plain_byte());
                endcase
                counted++;
            end
            else if (pick < 88)
            begin
                queue_byte(CHAR_W'($urandom_range(255)));
                counted++;
            end
            else
            begin
                len = $urandom_range(3);
                for (k = 0; k < len; k++)
                begin
                    queue_byte(plain_byte());
                    counted++;
                end
                len = len + $urandom_range(1, 4);
                for (k = 0; k < len; k++)
                    queue_byte(CH_BS_KEY);
                queue_byte(CH_EOT);
                counted++;
            end
        end
    endtask

    initial
    begin : stimulus
        int k;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part, under the reset limit of 256. The sender idles
        // rarely and the receiver often.
        sender_idle_pct = 19;
        recv_idle_pct   = 79;
        queue_byte(CH_BS_KEY);      // backspace on an empty line gives no result
        queue_byte(CH_EOT);         // empty line finishes with length zero
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_byte("A");
        queue_byte(CH_BS_KEY);
        queue_byte(CH_BS_KEY);
        queue_byte(CH_BS_KEY);
        queue_byte(CH_BS_KEY);      // erased back to the start, nothing to remove
        queue_byte(CH_CR);          // CR is stored but echoed as LF
        queue_byte("x");
        queue_byte(CH_LF);
        queue_byte("q");
        queue_byte("w");
        queue_byte(CH_EOT);
        queue_byte("a");            // leave three bytes taken on an open line
        queue_byte("b");
        queue_byte("c");

        // Limit dropped below what the open line has already taken.
        begin_phase(1, 19, 79);
        queue_byte("z");
        queue_byte("k");            // a limit of one ends every line at once
        queue_byte(CH_BS_KEY);      // empty-line backspace still reaches the limit

        // Backspace that hits the limit: the clearing store is left out.
        begin_phase(3, 19, 79);
        queue_byte("a");
        queue_byte("b");
        queue_byte(CH_BS_KEY);

        // A zero limit behaves as one, anything above the line size as 256.
        begin_phase(0, 19, 79);
        queue_byte("m");
        begin_phase(511, 19, 79);
        queue_byte("n");
        queue_byte(CH_EOT);

        // Random part over several limits and both idling patterns.
        begin_phase(256, 19, 79);
        queue_random_traffic(8);
        begin_phase(8, 19, 79);
        queue_random_traffic(6);
        begin_phase(300, 79, 19);
        queue_random_traffic(8);
        begin_phase(1, 79, 19);
        queue_random_traffic(4);

        // No idling, plus one long receiver hold while bytes keep coming.
        begin_phase(40, 0, 0);
        queue_random_traffic(10);
        hold_request = 1'b1;

        // One full-size line that ends at the last buffer entry.
        begin_phase(256, 0, 0);
        queue_byte(CH_EOT);
        for (k = 0; k < MAX_LINE - 1; k++)
            queue_byte(plain_byte());
        queue_byte(CH_LF);

        wait_until_idle();
        run_done = 1'b1;

        $display("Covered %0d console bytes and %0d results, ", bytes_accepted, results_seen,
                 "%0d lines finished, under %0d limit settings.",
                 lines_finished, limits_written);
        $display("Mismatches: %0d, results still owed: %0d.",
                 error_count, line_results_due.size());
        if (error_count == 0 && line_results_due.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### files.f
hw/rtl/cle_pkg.sv
hw/rtl/cle_decode.sv
hw/rtl/cle_serializer.sv
hw/rtl/console_line_editor_unit.sv
sim/tb_console_line_editor_unit.sv
